/* hw/rtl/bit_flip_value_range_top_macros.svh */
// Assertion macros shared by the bit flip value range modules.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef BIT_FLIP_VALUE_RANGE_TOP_MACROS_SVH
`define BIT_FLIP_VALUE_RANGE_TOP_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define BFVR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define BFVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bfvr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvr_pkg
// Shared types, codes and helpers of the bit flip value range block.
// ----------------------------------------------------------------------------
package bfvr_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned BW_W    = 5;
  localparam int unsigned POP_W   = 6;

  localparam logic [FUNC_W-1:0] FUNC_EXACT           = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXACT_KEEP_SIGN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_AT_MOST         = 2'd2;

  localparam logic [BW_W-1:0] BIT_WIDTH_RESET = 5'd8;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  function automatic logic [POP_W-1:0] popcount32(input logic [31:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/bit_flip_value_range_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_flip_value_range_top
// Least and greatest value reachable by flipping bits of a quantized value.
// ----------------------------------------------------------------------------
// Usage:
// The cfg channel sets the bit width (1 to MAX_BITS) and is always ready; the
// user must write it only while no item is in flight, which the block itself
// does not enforce. An input transfer carries the mode in in_tuser and the
// value, flip count and base mask in in_tdata. The block scans every mask of
// the effective width w, one mask per cycle, and takes a new item only once
// the result of the last one has gone to the output register. The mask
// counter feeds a single popcount and compare path.
// The result sits in an output register; while the receiver stalls it holds
// its value and a finished scan waits, so no new item is taken until the
// register is free.
// Reset sets the width to 8, empties the output register and idles the scan.
// ----------------------------------------------------------------------------
module bit_flip_value_range_top #(
  parameter int unsigned MAX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[15:0], flip_count[20:16], base_mask[36:21], zero fill above.
  input  logic [39:0] in_tdata,
  // func[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // range_low[15:0], range_high[31:16].
  output logic [31:0] out_tdata,
  // found[0].
  output logic [0:0]  out_tuser
);

  bfvr_pkg::cmd_t    cmd;
  bfvr_pkg::status_t status;
  logic signed [15:0] range_low;
  logic signed [15:0] range_high;
  logic               found;

  assign cfg_ready = 1'b1;

  bfvr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  bfvr_datapath #(
    .MAX_BITS (MAX_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_bit_width (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .func          (in_tuser),
    .value         (in_tdata[15:0]),
    .flip_count    (in_tdata[20:16]),
    .base_mask     (in_tdata[36:21]),
    .range_low     (range_low),
    .range_high    (range_high),
    .found         (found)
  );

  assign out_tdata = {range_high, range_low};
  assign out_tuser = found;

endmodule

/* hw/rtl/bfvr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvr_datapath
// Mask counter, qualification logic, running bounds and result register.
// ----------------------------------------------------------------------------
`include "bit_flip_value_range_top_macros.svh"

module bfvr_datapath #(
  parameter int unsigned MAX_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bfvr_pkg::BW_W-1:0]          cfg_bit_width,
  input  bfvr_pkg::cmd_t                     cmd,
  output bfvr_pkg::status_t                  status,
  input  logic [bfvr_pkg::FUNC_W-1:0]        func,
  input  logic signed [bfvr_pkg::VALUE_W-1:0] value,
  input  logic [bfvr_pkg::COUNT_W-1:0]       flip_count,
  input  logic [bfvr_pkg::MASK_W-1:0]        base_mask,
  output logic signed [bfvr_pkg::VALUE_W-1:0] range_low,
  output logic signed [bfvr_pkg::VALUE_W-1:0] range_high,
  output logic                               found
);

  localparam int unsigned MB = MAX_BITS;
  localparam logic [MB-1:0] ONES = '1;
  localparam logic [bfvr_pkg::BW_W-1:0] MB_CODE = bfvr_pkg::BW_W'(MAX_BITS);

  logic [bfvr_pkg::BW_W-1:0]    bw_r;
  logic [bfvr_pkg::BW_W-1:0]    w_eff;
  logic [MB-1:0]                wmask;
  logic [MB-1:0]                sign_bit;
  logic [MB-1:0]                cnt_r, cnt_nxt;
  logic [MB-1:0]                v_r;
  logic [MB-1:0]                base_r;
  logic [bfvr_pkg::FUNC_W-1:0]  func_r;
  logic [bfvr_pkg::POP_W-1:0]   limit_r;
  logic [bfvr_pkg::POP_W-1:0]   target_r;
  logic [MB-1:0]                min_r, min_nxt;
  logic [MB-1:0]                max_r, max_nxt;
  logic                         found_r, found_nxt;
  logic [MB-1:0]                v_in;
  logic [MB-1:0]                base_in;
  logic [bfvr_pkg::POP_W-1:0]   pop_m;
  logic [MB-1:0]                flipped;
  logic [MB-1:0]                cand;
  logic                         ok;
  logic signed [31:0]           min_ext;
  logic signed [31:0]           max_ext;
  logic signed [31:0]           value_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= bfvr_pkg::BIT_WIDTH_RESET;
    end else if (cfg_we) begin
      bw_r <= cfg_bit_width;
    end
  end

  always_comb begin
    if (bw_r == '0) begin
      w_eff = bfvr_pkg::BW_W'(1);
    end else if (bw_r > MB_CODE) begin
      w_eff = MB_CODE;
    end else begin
      w_eff = bw_r;
    end
  end

  assign wmask    = ONES >> (MB_CODE - w_eff);
  assign sign_bit = MB'(1) << (w_eff - bfvr_pkg::BW_W'(1));

  assign value_ext = 32'(value);
  assign v_in      = value_ext[MB-1:0] & wmask;
  assign base_in   = MB'(32'(base_mask)) & wmask;

  assign pop_m   = bfvr_pkg::popcount32(32'(cnt_r));
  assign flipped = v_r ^ cnt_r;
  assign cand    = ((flipped & sign_bit) != '0) ? (flipped | ~wmask) : flipped;

  always_comb begin
    unique case (func_r)
      bfvr_pkg::FUNC_EXACT: begin
        ok = ((cnt_r & base_r) == base_r) && (pop_m == target_r);
      end
      bfvr_pkg::FUNC_EXACT_KEEP_SIGN: begin
        ok = ((cnt_r & base_r) == base_r) && (pop_m == target_r) &&
             ((cnt_r & ~base_r & sign_bit) == '0);
      end
      bfvr_pkg::FUNC_AT_MOST: begin
        ok = (pop_m <= limit_r);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign status.last = (cnt_r == wmask);

  always_comb begin
    cnt_nxt   = cnt_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    found_nxt = found_r;
    if (cmd.load) begin
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      min_nxt   = '0;
      max_nxt   = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + MB'(1);
      if (ok) begin
        if (!found_r || ($signed(cand) < $signed(min_r))) begin
          min_nxt = cand;
        end
        if (!found_r || ($signed(cand) > $signed(max_r))) begin
          max_nxt = cand;
        end
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
      found_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r      <= v_in;
      base_r   <= base_in;
      func_r   <= func;
      limit_r  <= bfvr_pkg::POP_W'(flip_count);
      target_r <= bfvr_pkg::POP_W'(flip_count) + bfvr_pkg::popcount32(32'(base_in));
    end
  end

  assign min_ext = 32'($signed(min_r));
  assign max_ext = 32'($signed(max_r));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      range_low  <= found_r ? min_ext[bfvr_pkg::VALUE_W-1:0] : '0;
      range_high <= found_r ? max_ext[bfvr_pkg::VALUE_W-1:0] : '0;
      found      <= found_r;
    end
  end

  `BFVR_ASSERT_NEXT(a_load_clears, cmd.load, (cnt_r == '0) && !found_r, "load must clear scan")
  `BFVR_ASSERT_NEXT(a_scan_advances, cmd.step && !status.last,
                    cnt_r == $past(cnt_r) + MB'(1), "mask counter must advance by one")

endmodule

/* hw/rtl/bfvr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvr_ctrl
// Sequencer that accepts an item, runs the mask scan and hands off results.
// ----------------------------------------------------------------------------
`include "bit_flip_value_range_top_macros.svh"

module bfvr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bfvr_pkg::status_t status,
  output bfvr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BFVR_ASSERT_NEXT(a_load_starts_run, cmd.load, state_r == ST_RUN, "load must start the scan")
  `BFVR_ASSERT_NEXT(a_last_finishes, (state_r == ST_RUN) && status.last,
                    state_r == ST_FIN, "scan must end after the last mask")
  `BFVR_ASSERT_NEXT(a_capture_shows, cmd.capture, out_tvalid, "captured result must be offered")

endmodule
